FILE: src/assert_macros.svh
// Assertion macros shared by the paper tape reader RTL.
// Included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/ptr_pkg.sv
// Package for the paper tape reader interface: operation codes, bit
// positions and the transaction structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptr_pkg;

	localparam int WORD_W  = 36;
	localparam int FRAME_W = 8;
	localparam int OP_W    = 3;
	localparam int LEVEL_W = 3;
	localparam int STROBE_W = 6;

	// Operation codes
	localparam logic [OP_W-1:0] OP_BUS_RESET = 3'd0;
	localparam logic [OP_W-1:0] OP_STATUS    = 3'd1;
	localparam logic [OP_W-1:0] OP_CONO      = 3'd2;
	localparam logic [OP_W-1:0] OP_DATAI     = 3'd3;
	localparam logic [OP_W-1:0] OP_FRAME     = 3'd4;
	localparam logic [OP_W-1:0] OP_MOTOR     = 3'd5;

	// CONO bit positions (040 binary, 020 busy, 010 flag)
	localparam int CONO_BIN_BIT  = 5;
	localparam int CONO_BUSY_BIT = 4;
	localparam int CONO_FLAG_BIT = 3;

	// Frame bit 0200 marks a binary frame to be strobed
	localparam int FRAME_STROBE_BIT = 7;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic               device_selected;
		logic [WORD_W-1:0]  bus_data;
		logic [FRAME_W-1:0] frame;
		logic               motor_value;
	} ptr_item_t;

	typedef struct packed {
		logic [WORD_W-1:0]  read_data;
		logic [LEVEL_W-1:0] interrupt_level;
		logic               frame_taken;
		logic               word_done;
	} ptr_result_t;

endpackage

`default_nettype wire

FILE: src/ptr_in_if.sv
// Input channel of the paper tape reader: valid/ready plus item fields.
// Depends on ptr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ptr_in_if
	import ptr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic               device_selected;
	logic [WORD_W-1:0]  bus_data;
	logic [FRAME_W-1:0] frame;
	logic               motor_value;

	modport source (output valid, operation, device_selected, bus_data, frame, motor_value,
		input ready);
	modport sink (input valid, operation, device_selected, bus_data, frame, motor_value,
		output ready);
endinterface

`default_nettype wire

FILE: src/ptr_out_if.sv
// Result channel of the paper tape reader: valid/ready plus result fields.
// Depends on ptr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ptr_out_if
	import ptr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [WORD_W-1:0]  read_data;
	logic [LEVEL_W-1:0] interrupt_level;
	logic               frame_taken;
	logic               word_done;

	modport source (output valid, read_data, interrupt_level, frame_taken, word_done,
		input ready);
	modport sink (input valid, read_data, interrupt_level, frame_taken, word_done,
		output ready);
endinterface

`default_nettype wire

FILE: src/ptr_in_reg.sv
// Input stage register: captures one item transaction per cycle while the stage is free to accept.
// Depends on ptr_pkg and ptr_in_if.
`timescale 1ns / 1ps
`default_nettype none

module ptr_in_reg
	import ptr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	ptr_in_if.sink     cmd,
	input  wire logic  advance,
	output ptr_item_t  item_s1,
	output logic       valid_s1
);

	// Stage accepts when empty or when its item moves on this cycle
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.operation       <= cmd.operation;
			item_s1.device_selected <= cmd.device_selected;
			item_s1.bus_data        <= cmd.bus_data;
			item_s1.frame           <= cmd.frame;
			item_s1.motor_value     <= cmd.motor_value;
		end
	end

endmodule

`default_nettype wire

FILE: src/ptr_core.sv
// Controller state and its next-state logic; forms the result of the
// item in the input stage. Depends on ptr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ptr_core
	import ptr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ptr_item_t  item_s1,
	input  wire logic       advance,
	output ptr_result_t     result
);

	logic [WORD_W-1:0]   word_q;
	logic [STROBE_W-1:0] strobe_q;
	logic                prog_q;
	logic                bin_q;
	logic                busy_q;
	logic                flag_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                motor_q;

	logic [WORD_W-1:0]   word_d;
	logic [STROBE_W-1:0] strobe_d;
	logic                prog_d;
	logic                bin_d;
	logic                busy_d;
	logic                flag_d;
	logic [LEVEL_W-1:0]  level_d;
	logic                motor_d;

	logic [WORD_W-1:0]   rd;
	logic                taken;
	logic                done;

	// Frame assembly terms
	logic [WORD_W-1:0]   word_base;
	logic [STROBE_W-1:0] strobe_base;
	logic                strobe_en;
	logic [STROBE_W-1:0] strobe_shift;
	logic [WORD_W-1:0]   word_shift;
	logic [STROBE_W-1:0] strobe_new;
	logic [WORD_W-1:0]   word_new;
	logic                sel;

	assign sel = item_s1.device_selected;

	always_comb begin
		word_base    = prog_q ? word_q : '0;
		strobe_base  = prog_q ? strobe_q : '0;
		strobe_en    = !bin_q || item_s1.frame[FRAME_STROBE_BIT];
		strobe_shift = {strobe_base[STROBE_W-2:0], 1'b1};
		// alpha mode keeps the top two frame bits above the six data bits
		word_shift   = {word_base[WORD_W-7:0], item_s1.frame[5:0]}
			| (bin_q ? '0 : {{(WORD_W-FRAME_W){1'b0}}, item_s1.frame[7:6], 6'b0});
		strobe_new   = strobe_en ? strobe_shift : strobe_base;
		word_new     = strobe_en ? word_shift : word_base;
	end

	// Next-state and result per operation
	always_comb begin
		word_d   = word_q;
		strobe_d = strobe_q;
		prog_d   = prog_q;
		bin_d    = bin_q;
		busy_d   = busy_q;
		flag_d   = flag_q;
		level_d  = level_q;
		motor_d  = motor_q;
		rd       = '0;
		taken    = 1'b0;
		done     = 1'b0;
		case (item_s1.operation)
			OP_BUS_RESET: begin
				level_d = '0;
				busy_d  = 1'b0;
				flag_d  = 1'b0;
				bin_d   = 1'b0;
				prog_d  = 1'b0;
			end
			OP_STATUS: begin
				if (sel) begin
					rd = {{(WORD_W-9){1'b0}}, motor_q, 2'b00, bin_q, busy_q, flag_q, level_q};
				end
			end
			OP_CONO: begin
				// clear then set
				if (sel) begin
					prog_d  = 1'b0;
					bin_d   = item_s1.bus_data[CONO_BIN_BIT];
					busy_d  = item_s1.bus_data[CONO_BUSY_BIT];
					flag_d  = item_s1.bus_data[CONO_FLAG_BIT];
					level_d = item_s1.bus_data[LEVEL_W-1:0];
				end
			end
			OP_DATAI: begin
				if (sel) begin
					rd     = word_q;
					flag_d = 1'b0;
					busy_d = 1'b1;
				end
			end
			OP_FRAME: begin
				if (busy_q && motor_q) begin
					taken    = 1'b1;
					word_d   = word_new;
					strobe_d = strobe_new;
					prog_d   = 1'b1;
					if (!bin_q || strobe_new[STROBE_W-1]) begin
						busy_d = 1'b0;
						flag_d = 1'b1;
						prog_d = 1'b0;
						done   = 1'b1;
					end
				end
			end
			OP_MOTOR: begin
				if (motor_q != item_s1.motor_value) begin
					motor_d = item_s1.motor_value;
					if (item_s1.motor_value) begin
						busy_d = 1'b0;
					end
					flag_d = 1'b1;
					prog_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.read_data       = rd;
		result.interrupt_level = flag_d ? level_d : '0;
		result.frame_taken     = taken;
		result.word_done       = done;
	end

	// State commits when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q   <= '0;
			strobe_q <= '0;
			prog_q   <= 1'b0;
			bin_q    <= 1'b0;
			busy_q   <= 1'b0;
			flag_q   <= 1'b0;
			level_q  <= '0;
			motor_q  <= 1'b0;
		end else if (advance) begin
			word_q   <= word_d;
			strobe_q <= strobe_d;
			prog_q   <= prog_d;
			bin_q    <= bin_d;
			busy_q   <= busy_d;
			flag_q   <= flag_d;
			level_q  <= level_d;
			motor_q  <= motor_d;
		end
	end

	// A finished word always consumed a frame
	`ASSERT_IMPL(a_done_taken, clk, arst_n, result.word_done, result.frame_taken, "word_done without frame_taken")
	// Finishing a word leaves the reader not busy with flag raised
	`ASSERT_NEXT(a_done_flag, clk, arst_n, advance && result.word_done, !busy_q && flag_q && !prog_q, "word completion state wrong")
	// A selected DATAI re-arms the reader
	`ASSERT_NEXT(a_datai_busy, clk, arst_n, advance && sel && (item_s1.operation == OP_DATAI), busy_q && !flag_q, "DATAI did not set busy and clear flag")

endmodule

`default_nettype wire

FILE: src/ptr_out_reg.sv
// Result register: holds one result transaction until the sink takes it.
// Depends on ptr_pkg and ptr_out_if.
`timescale 1ns / 1ps
`default_nettype none

module ptr_out_reg
	import ptr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ptr_result_t result,
	input  wire logic        valid_s1,
	output logic             advance,
	ptr_out_if.source        rsp
);

	ptr_result_t res_s2;
	logic        valid_s2;
	logic        can_load;

	// Register is free when empty or being drained
	assign can_load = !valid_s2 || rsp.ready;
	assign advance  = valid_s1 && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.read_data       = res_s2.read_data;
	assign rsp.interrupt_level = res_s2.interrupt_level;
	assign rsp.frame_taken     = res_s2.frame_taken;
	assign rsp.word_done       = res_s2.word_done;

endmodule

`default_nettype wire

FILE: src/paper_tape_reader_interface.sv
// Paper tape reader controller. An accepted item goes through the input
// register, then the result register; an output stall holds its result.
// Throughput: one item per cycle while rsp is not stalled; the state registers update in one pass.
// Reset: arst_n clears all controller state and both stage valids at once.
// Depends on ptr_pkg, ptr_in_if, ptr_out_if, ptr_in_reg, ptr_core, ptr_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module paper_tape_reader_interface
	import ptr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	ptr_in_if.sink    cmd,
	ptr_out_if.source rsp
);

	ptr_item_t   item_s1;
	ptr_result_t result;
	logic        valid_s1;
	logic        advance;

	ptr_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.advance  (advance),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1)
	);

	ptr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.advance (advance),
		.result  (result)
	);

	ptr_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.result   (result),
		.valid_s1 (valid_s1),
		.advance  (advance),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire
